// ===== rtl/implicit_array_bst_table_macros.svh =====
// Assertion macros for the implicit array search tree RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef IMPLICIT_ARRAY_BST_TABLE_MACROS_SVH
`define IMPLICIT_ARRAY_BST_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define IABT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IABT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/iabt_pkg.sv =====
// Shared types and constants for the implicit array search tree.
// No dependencies; used by iabt_cell and implicit_array_bst_table.
`default_nettype none

package iabt_pkg;

  localparam int HEIGHT_W = 4;
  localparam int HEIGHT_MAX = 15;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                active;
    logic                kind;
    logic                done;
    logic                found;
    logic [HEIGHT_W-1:0] depth;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/iabt_cell.sv =====
// One tree level: holds the slots of its level and steps a walking beat down.
// Depends on iabt_pkg.
`default_nettype none

module iabt_cell #(
  parameter int LEVEL    = 1,
  parameter int LEVELS   = 10,
  parameter int KEY_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  clr_en,
  input  wire logic [LEVELS-2:0]     clr_addr,
  input  wire iabt_pkg::ctrl_t       in_ctrl,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [LEVELS-1:0]     in_path,
  output iabt_pkg::ctrl_t            out_ctrl,
  output logic      [KEY_BITS-1:0]   out_key,
  output logic      [LEVELS-1:0]     out_path
);

  localparam int AW = (LEVEL > 1) ? LEVEL - 1 : 1;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int DEPTH_SAT = (LEVEL > iabt_pkg::HEIGHT_MAX) ? iabt_pkg::HEIGHT_MAX : LEVEL;
  localparam logic [iabt_pkg::HEIGHT_W-1:0] DEPTH_CODE = iabt_pkg::HEIGHT_W'(DEPTH_SAT);

  logic [KEY_BITS-1:0] mem [0:MEM_DEPTH-1];
  logic [KEY_BITS-1:0] rdata;
  iabt_pkg::ctrl_t     ctrl_q;
  logic [KEY_BITS-1:0] key_q;
  logic [LEVELS-1:0]   path_q;

  logic          hit;
  logic          slot_empty;
  logic          slot_equal;
  logic          key_less;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [KEY_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= in_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    key_q  <= in_key;
    path_q <= in_path;
    rdata  <= mem[in_path[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign hit        = ctrl_q.active && !ctrl_q.done;
  assign slot_empty = (rdata == '0);
  assign slot_equal = (rdata == key_q);
  assign key_less   = ($signed(key_q) < $signed(rdata));

  always_comb begin
    out_ctrl = ctrl_q;
    out_key  = key_q;
    out_path = path_q;
    wr_en    = 1'b0;
    wr_addr  = path_q[AW-1:0];
    wr_data  = key_q;
    if (clr_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr[AW-1:0];
      wr_data = '0;
    end else if (hit) begin
      priority if (slot_empty) begin
        out_ctrl.done = 1'b1;
        if (ctrl_q.kind == iabt_pkg::KIND_INSERT) begin
          out_ctrl.depth = DEPTH_CODE;
          wr_en          = 1'b1;
        end
      end else if (slot_equal) begin
        out_ctrl.done  = 1'b1;
        out_ctrl.found = 1'b1;
      end else begin
        out_path = {path_q[LEVELS-2:0], ~key_less};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/implicit_array_bst_table.sv =====
// Binary search tree table in heap layout, walked by a chain of level cells.
// Depends on iabt_pkg, iabt_cell and implicit_array_bst_table_macros.svh.
//
// Use: one input beat on s_axis carries a command. s_axis_tuser is the kind
// (0 insert, 1 search) and s_axis_tdata holds the signed key. Every command
// gives exactly one result beat on m_axis: found, overflow and the greatest
// insert depth so far. Key zero marks an empty slot; a search for zero is
// always found, and an insert past the last level is dropped with overflow.
// A command passes one level cell per cycle, one memory read per level, and
// a new command is taken only once the previous one has left the chain and
// the control is back in idle, so commands never overlap in the chain.
// After reset every level memory is swept to zero, one address per cycle over
// 2^(LEVELS-1) addresses (512 at the default depth); s_axis_tready stays low
// until the sweep is done. If the receiver stalls, the result waits in the
// output register and one more command is still taken; its result waits in a
// second register, and input is held off until the output side drains.
`default_nettype none

`include "implicit_array_bst_table_macros.svh"

module implicit_array_bst_table #(
  parameter int LEVELS   = 10,
  parameter int KEY_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Bits from low: key (KEY_BITS, signed), zero fill.
  input  wire logic [((KEY_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // Bits from low: kind.
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Bits from low: found, overflow, tree_height (4), zero fill.
  output logic [7:0]                             m_axis_tdata
);

  localparam int CW = LEVELS - 1;
  localparam logic [CW-1:0] CLR_LAST = '1;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  localparam int HW = iabt_pkg::HEIGHT_W;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] clr_cnt;
  logic          clr_en;
  logic          accept;
  logic          take;
  logic          exit_beat;

  iabt_pkg::ctrl_t     link_ctrl [0:LEVELS];
  logic [KEY_BITS-1:0] link_key  [0:LEVELS];
  logic [LEVELS-1:0]   link_path [0:LEVELS];

  logic [HW-1:0] max_height;
  logic [HW-1:0] max_height_next;
  logic          res_found;
  logic          res_ovf;

  logic          out_valid;
  logic          out_found;
  logic          out_ovf;
  logic [HW-1:0] out_height;
  logic          spare_valid;
  logic          spare_found;
  logic          spare_ovf;
  logic [HW-1:0] spare_height;

  assign clr_en        = (state == ST_CLEAR);
  assign s_axis_tready = (state == ST_IDLE) && !spare_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = m_axis_tvalid && m_axis_tready;
  assign exit_beat     = link_ctrl[LEVELS].active;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (exit_beat) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clr_en) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    link_ctrl[0]        = '0;
    link_ctrl[0].active = accept;
    link_ctrl[0].kind   = s_axis_tuser[0];
    link_key[0]         = s_axis_tdata[KEY_BITS-1:0];
    link_path[0]        = '0;
  end

  for (genvar g = 1; g <= LEVELS; g++) begin : g_level
    iabt_cell #(
      .LEVEL    (g),
      .LEVELS   (LEVELS),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clr_en   (clr_en),
      .clr_addr (clr_cnt),
      .in_ctrl  (link_ctrl[g-1]),
      .in_key   (link_key[g-1]),
      .in_path  (link_path[g-1]),
      .out_ctrl (link_ctrl[g]),
      .out_key  (link_key[g]),
      .out_path (link_path[g])
    );
  end

  always_comb begin
    res_found = link_ctrl[LEVELS].found;
    res_ovf   = 1'b0;
    if (link_ctrl[LEVELS].kind == iabt_pkg::KIND_SEARCH) begin
      if (link_key[LEVELS] == '0) begin
        res_found = 1'b1;
      end
    end else if (!link_ctrl[LEVELS].done) begin
      res_ovf = 1'b1;
    end
    max_height_next = max_height;
    if (link_ctrl[LEVELS].depth > max_height) begin
      max_height_next = link_ctrl[LEVELS].depth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_height  <= '0;
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (exit_beat) begin
        max_height <= max_height_next;
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          spare_valid <= 1'b1;
        end
      end else if (take) begin
        if (spare_valid) begin
          spare_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exit_beat) begin
      if (!out_valid || take) begin
        out_found  <= res_found;
        out_ovf    <= res_ovf;
        out_height <= max_height_next;
      end else begin
        spare_found  <= res_found;
        spare_ovf    <= res_ovf;
        spare_height <= max_height_next;
      end
    end else if (take && spare_valid) begin
      out_found  <= spare_found;
      out_ovf    <= spare_ovf;
      out_height <= spare_height;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_height, out_ovf, out_found};

  `IABT_ASSERT_NEXT(a_accept_walks, accept, state == ST_WALK, "accepted beat did not start a walk")
  `IABT_ASSERT_NOW(a_exit_in_walk, exit_beat, state == ST_WALK, "beat left the chain outside a walk")
  `IABT_ASSERT_NOW(a_spare_behind_out, spare_valid, out_valid, "spare result without output result")
  `IABT_ASSERT_NOW(a_ovf_not_found, m_axis_tvalid, !(out_found && out_ovf), "found and overflow both set")
  `IABT_ASSERT_NEXT(a_height_grows, state != ST_CLEAR, max_height >= $past(max_height), "tree height fell")

endmodule

`default_nettype wire
